>>> rtl/core/srpg_pkg.sv
// shared types and constants of the stepper ramp pulse generator
`default_nettype none
package srpg_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_REL_MOVE = 3'd1;
  localparam logic [2:0] REQ_ABS_MOVE = 3'd2;
  localparam logic [2:0] REQ_STOP     = 3'd3;
  localparam logic [2:0] REQ_ZERO_POS = 3'd4;

  localparam logic [1:0] REG_START_INTERVAL = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL   = 2'd1;

  localparam logic [23:0] START_INTERVAL_RST = 24'd1587200;
  localparam logic [15:0] MIN_INTERVAL_RST   = 16'd200;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_POST = 3'b100
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

endpackage
`default_nettype wire

>>> rtl/core/srpg_muldiv.sv
// bit-serial multiply then restoring divide: quo = floor(c * mul / div)
`default_nettype none
module srpg_muldiv #(
  parameter int IV_W = 24,
  parameter int F_W  = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [IV_W-1:0]   c_in,
  input  wire logic [F_W-1:0]    mul_in,
  input  wire logic [F_W-1:0]    div_in,
  output logic                   done,
  output logic [IV_W:0]          quo
);

  localparam int Q_W  = IV_W + 1;
  localparam int P_W  = IV_W + F_W;
  localparam int MAXN = (F_W > Q_W) ? F_W : Q_W;
  localparam int CW   = $clog2(MAXN + 1);

  srpg_pkg::md_state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IV_W-1:0] c_r, c_nxt;
  logic [F_W-1:0]  div_r, div_nxt;
  logic [IV_W-1:0] acc_r, acc_nxt;
  logic [F_W-1:0]  mlo_r, mlo_nxt;
  logic [F_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]  quo_r, quo_nxt;
  logic            done_r, done_nxt;

  logic [IV_W:0]   sum;
  logic [P_W-1:0]  prod;
  logic [F_W:0]    trial;
  logic [F_W:0]    diff;
  logic            ge;

  assign sum   = {1'b0, acc_r} + (mlo_r[0] ? {1'b0, c_r} : {(IV_W+1){1'b0}});
  assign prod  = {sum[IV_W:1], sum[0], mlo_r[F_W-1:1]};
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    c_nxt     = c_r;
    div_nxt   = div_r;
    acc_nxt   = acc_r;
    mlo_nxt   = mlo_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      srpg_pkg::MD_IDLE: begin
        if (start) begin
          c_nxt     = c_in;
          div_nxt   = div_in;
          acc_nxt   = '0;
          mlo_nxt   = mul_in;
          cnt_nxt   = CW'(F_W - 1);
          state_nxt = srpg_pkg::MD_MUL;
        end
      end
      srpg_pkg::MD_MUL: begin
        acc_nxt = sum[IV_W:1];
        mlo_nxt = {sum[0], mlo_r[F_W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = srpg_pkg::MD_DIV;
          cnt_nxt   = CW'(Q_W - 1);
          rem_nxt   = F_W'(prod >> Q_W);
          quo_nxt   = prod[Q_W-1:0];
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      srpg_pkg::MD_DIV: begin
        rem_nxt = ge ? diff[F_W-1:0] : trial[F_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = srpg_pkg::MD_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = srpg_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpg_pkg::MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    c_r   <= c_nxt;
    div_r <= div_nxt;
    acc_r <= acc_nxt;
    mlo_r <= mlo_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/stepper_ramp_pulse_generator.sv
// step/direction pulse generator with a real-time linear speed ramp
// timing: an accepted request goes through ST_POST to the output registers; a tick that ends a step
//   while ramping first waits in ST_CALC for the bit-serial multiply and divide
// flow: in_ready is high only in ST_IDLE, so a new request is taken once the last result has been
//   posted; a ramping step also waits for the bit-serial multiply/divide
// reset: synchronous active-low rst_n; idle, position zero, default registers
`default_nettype none
module stepper_ramp_pulse_generator #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [31:0] in_step_count,
  input  wire logic signed [31:0] in_target_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_step_level,
  output logic                    out_dir_level,
  output logic                    out_moving,
  output logic signed [31:0]      out_position,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [23:0]        cfg_data
);

  localparam int CB   = COUNT_BITS;
  localparam int IV_W = 16 + FRAC_BITS;
  localparam int F_W  = CB + 2;
  localparam int Q_W  = IV_W + 1;

  srpg_pkg::ctrl_state_t state_r, state_nxt;

  logic [23:0]     start_iv_r;
  logic [15:0]     min_iv_r;
  logic [31:0]     pos_r, pos_nxt;
  logic [CB-1:0]   total_r, total_nxt;
  logic [CB-1:0]   done_r, done_nxt;
  logic [CB-1:0]   ramp_r, ramp_nxt;
  logic [CB-1:0]   n_r, n_nxt;
  logic [IV_W-1:0] iv_r, iv_nxt;
  logic [15:0]     half_r, half_nxt;
  logic [15:0]     wait_r, wait_nxt;
  logic            pulse_r, pulse_nxt;
  logic            neg_r, neg_nxt;
  logic            cmpl_r, cmpl_nxt;
  logic            accel_r, accel_nxt;

  logic            out_valid_r;
  logic            out_step_r, out_dir_r, out_mov_r;
  logic [31:0]     out_pos_r;

  logic            accept;
  logic            md_start;
  logic [F_W-1:0]  md_mul, md_div;
  logic            md_done;
  logic [Q_W-1:0]  md_quo;

  logic [IV_W-1:0] loaded_start;
  logic [IV_W-1:0] lim;
  logic [31:0]     delta;
  logic [31:0]     mag;
  logic            sat;
  logic [15:0]     half_calc;

  assign loaded_start = IV_W'({start_iv_r, {FRAC_BITS{1'b0}}} >> 8);
  assign lim          = IV_W'({min_iv_r, {FRAC_BITS{1'b0}}});
  assign accept       = in_valid && in_ready;
  assign in_ready     = (state_r == srpg_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;

  always_comb begin
    logic [IV_W-1:0] c_new;
    logic [CB-1:0]   n_tmp;
    logic [15:0]     h;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    done_nxt  = done_r;
    ramp_nxt  = ramp_r;
    n_nxt     = n_r;
    iv_nxt    = iv_r;
    half_nxt  = half_r;
    wait_nxt  = wait_r;
    pulse_nxt = pulse_r;
    neg_nxt   = neg_r;
    cmpl_nxt  = cmpl_r;
    accel_nxt = accel_r;
    md_start  = 1'b0;
    md_mul    = '0;
    md_div    = '0;
    delta     = (in_req_type == srpg_pkg::REQ_ABS_MOVE) ?
                32'(in_target_position) - pos_r : 32'(in_step_count);
    mag       = delta[31] ? (32'd0 - delta) : delta;
    sat       = ((33'(mag) >> CB) != 33'd0);
    half_calc = 16'(loaded_start >> (FRAC_BITS + 1));
    c_new     = '0;
    n_tmp     = '0;
    h         = '0;
    unique case (state_r)
      srpg_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = srpg_pkg::ST_POST;
          unique case (in_req_type)
            srpg_pkg::REQ_TICK: begin
              if (!cmpl_r) begin
                if (wait_r > 16'd1) begin
                  wait_nxt = wait_r - 16'd1;
                end else if (done_r >= total_r) begin
                  cmpl_nxt = 1'b1;
                end else if (!pulse_r) begin
                  pulse_nxt = 1'b1;
                  wait_nxt  = (half_r == 16'd0) ? 16'd1 : half_r;
                end else begin
                  pulse_nxt = 1'b0;
                  done_nxt  = done_r + 1'b1;
                  pos_nxt   = neg_r ? pos_r - 32'd1 : pos_r + 32'd1;
                  if (ramp_r == '0) begin
                    n_tmp     = (n_r != {CB{1'b1}}) ? n_r + 1'b1 : n_r;
                    n_nxt     = n_tmp;
                    accel_nxt = 1'b1;
                    md_start  = 1'b1;
                    md_mul    = {n_tmp, 2'b00} - 1'b1;
                    md_div    = {n_tmp, 2'b00} + 1'b1;
                    state_nxt = srpg_pkg::ST_CALC;
                  end else if (ramp_r <= total_r && done_nxt >= total_r - ramp_r) begin
                    n_tmp     = (n_r > 1) ? n_r - 1'b1 : n_r;
                    if (n_tmp == '0) n_tmp = CB'(1);
                    n_nxt     = n_tmp;
                    accel_nxt = 1'b0;
                    md_start  = 1'b1;
                    md_mul    = {n_tmp, 2'b00} + 1'b1;
                    md_div    = {n_tmp, 2'b00} - 1'b1;
                    state_nxt = srpg_pkg::ST_CALC;
                  end else begin
                    h        = 16'(iv_r >> (FRAC_BITS + 1));
                    half_nxt = h;
                    wait_nxt = (h == 16'd0) ? 16'd1 : h;
                  end
                end
              end
            end
            srpg_pkg::REQ_REL_MOVE, srpg_pkg::REQ_ABS_MOVE: begin
              total_nxt = sat ? {CB{1'b1}} : mag[CB-1:0];
              done_nxt  = '0;
              ramp_nxt  = '0;
              n_nxt     = '0;
              cmpl_nxt  = 1'b0;
              pulse_nxt = 1'b0;
              iv_nxt    = loaded_start;
              half_nxt  = half_calc;
              neg_nxt   = delta[31];
              wait_nxt  = (half_calc == 16'd0) ? 16'd1 : half_calc;
            end
            srpg_pkg::REQ_STOP: begin
              cmpl_nxt  = 1'b1;
              pulse_nxt = 1'b0;
            end
            srpg_pkg::REQ_ZERO_POS: begin
              pos_nxt   = '0;
              done_nxt  = '0;
              total_nxt = '0;
              ramp_nxt  = '0;
              n_nxt     = '0;
              cmpl_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      srpg_pkg::ST_CALC: begin
        if (md_done) begin
          if (accel_r) begin
            c_new = md_quo[IV_W-1:0];
            if (md_quo <= {1'b0, lim}) begin
              c_new    = lim;
              ramp_nxt = done_r;
            end
            if (done_r >= (total_r >> 1)) ramp_nxt = done_r;
          end else begin
            c_new = md_quo[IV_W] ? {IV_W{1'b1}} : md_quo[IV_W-1:0];
          end
          iv_nxt    = c_new;
          h         = 16'(c_new >> (FRAC_BITS + 1));
          half_nxt  = h;
          wait_nxt  = (h == 16'd0) ? 16'd1 : h;
          state_nxt = srpg_pkg::ST_POST;
        end
      end
      srpg_pkg::ST_POST: begin
        if (!out_valid_r || out_ready) state_nxt = srpg_pkg::ST_IDLE;
      end
      default: state_nxt = srpg_pkg::ST_IDLE;
    endcase
  end

  srpg_muldiv #(
    .IV_W (IV_W),
    .F_W  (F_W)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .c_in   (iv_r),
    .mul_in (md_mul),
    .div_in (md_div),
    .done   (md_done),
    .quo    (md_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srpg_pkg::ST_IDLE;
      start_iv_r  <= srpg_pkg::START_INTERVAL_RST;
      min_iv_r    <= srpg_pkg::MIN_INTERVAL_RST;
      pos_r       <= '0;
      total_r     <= '0;
      done_r      <= '0;
      ramp_r      <= '0;
      n_r         <= '0;
      iv_r        <= IV_W'({srpg_pkg::START_INTERVAL_RST, {FRAC_BITS{1'b0}}} >> 8);
      half_r      <= '0;
      wait_r      <= '0;
      pulse_r     <= 1'b0;
      neg_r       <= 1'b0;
      cmpl_r      <= 1'b1;
      accel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
      ramp_r  <= ramp_nxt;
      n_r     <= n_nxt;
      iv_r    <= iv_nxt;
      half_r  <= half_nxt;
      wait_r  <= wait_nxt;
      pulse_r <= pulse_nxt;
      neg_r   <= neg_nxt;
      cmpl_r  <= cmpl_nxt;
      accel_r <= accel_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == srpg_pkg::REG_START_INTERVAL) start_iv_r <= cfg_data;
        if (cfg_addr == srpg_pkg::REG_MIN_INTERVAL)   min_iv_r   <= cfg_data[15:0];
      end
      if (state_r == srpg_pkg::ST_POST && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == srpg_pkg::ST_POST && (!out_valid_r || out_ready)) begin
      out_step_r <= pulse_r;
      out_dir_r  <= neg_r;
      out_mov_r  <= !cmpl_r;
      out_pos_r  <= pos_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_level = out_step_r;
  assign out_dir_level  = out_dir_r;
  assign out_moving     = out_mov_r;
  assign out_position   = out_pos_r;

endmodule
`default_nettype wire

>>> tb/sv/tb_stepper_ramp_pulse_generator.sv
// testbench for the stepper ramp pulse generator: random and directed commands checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_stepper_ramp_pulse_generator;

  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned IV_MAX  = 64'hFF_FFFF;
  localparam int LIMIT_CYCLES = 4_000_000;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] steps;
    logic signed [31:0] target;
  } motion_cmd_t;

  typedef struct {
    logic               step_lvl;
    logic               dir_lvl;
    logic               busy;
    logic signed [31:0] pos;
  } motor_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic signed [31:0] in_step_count = '0;
  logic signed [31:0] in_target_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_step_level, out_dir_level, out_moving;
  logic signed [31:0] out_position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_addr = '0;
  logic [23:0] cfg_data = '0;

  stepper_ramp_pulse_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_step_count(in_step_count), .in_target_position(in_target_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_step_level(out_step_level),
    .out_dir_level(out_dir_level), .out_moving(out_moving), .out_position(out_position),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  motion_cmd_t   pending_cmds[$];
  motor_status_t expected_status[$];
  logic quiet = 1'b0;
  int cycles = 0;
  int mismatches = 0;
  int cmds_sent = 0;
  int status_seen = 0;
  int steps_made = 0;

  // predictor state
  logic [23:0] set_start;
  logic [15:0] set_min;
  logic [31:0] m_pos;
  longint unsigned m_total, m_done, m_ramp, m_accel, m_ivl;
  logic [15:0] m_half, m_wait;
  logic m_pulse, m_neg, m_idle;

  function automatic logic [15:0] half_interval(input longint unsigned c);
    longint unsigned h;
    h = c >> 9;
    return (h > 64'hFFFF) ? 16'hFFFF : h[15:0];
  endfunction

  task automatic begin_move(input logic [31:0] delta);
    logic [31:0] mag;
    mag = delta[31] ? (32'd0 - delta) : delta;
    m_total = mag;
    m_done = 0;
    m_ramp = 0;
    m_accel = 0;
    m_idle = 1'b0;
    m_pulse = 1'b0;
    m_ivl = set_start;
    m_half = half_interval(m_ivl);
    m_neg = delta[31];
    m_wait = (m_half == 0) ? 16'd1 : m_half;
  endtask

  task automatic advance_motion(input motion_cmd_t c);
    longint unsigned iv, lim;
    motor_status_t s;
    case (c.kind)
      srpg_pkg::REQ_TICK: begin
        if (!m_idle) begin
          if (m_wait > 1) begin
            m_wait = m_wait - 16'd1;
          end else if (m_done >= m_total) begin
            m_idle = 1'b1;
          end else if (!m_pulse) begin
            m_pulse = 1'b1;
            m_wait = (m_half == 0) ? 16'd1 : m_half;
          end else begin
            m_pulse = 1'b0;
            m_done++;
            steps_made++;
            m_pos = m_pos + (m_neg ? 32'hFFFF_FFFF : 32'd1);
            iv = m_ivl;
            lim = longint'(set_min) << 8;
            if (m_ramp == 0) begin
              if (m_accel < CNT_MAX) m_accel++;
              iv = (iv * (4 * m_accel - 1)) / (4 * m_accel + 1);
              if (iv <= lim) begin
                iv = lim;
                m_ramp = m_done;
              end
              if (m_done >= m_total / 2) m_ramp = m_done;
            end else if (m_ramp <= m_total && m_done >= m_total - m_ramp) begin
              if (m_accel > 1) m_accel--;
              if (m_accel == 0) m_accel = 1;
              iv = (iv * (4 * m_accel + 1)) / (4 * m_accel - 1);
            end
            m_ivl = (iv > IV_MAX) ? IV_MAX : iv;
            m_half = half_interval(m_ivl);
            m_wait = (m_half == 0) ? 16'd1 : m_half;
          end
        end
      end
      srpg_pkg::REQ_REL_MOVE: begin_move(c.steps);
      srpg_pkg::REQ_ABS_MOVE: begin_move(c.target - m_pos);
      srpg_pkg::REQ_STOP: begin
        m_idle = 1'b1;
        m_pulse = 1'b0;
      end
      srpg_pkg::REQ_ZERO_POS: begin
        m_pos = 0;
        m_done = 0;
        m_total = 0;
        m_ramp = 0;
        m_accel = 0;
        m_idle = 1'b1;
      end
      default: ;
    endcase
    s.step_lvl = m_pulse;
    s.dir_lvl = m_neg;
    s.busy = ~m_idle;
    s.pos = m_pos;
    expected_status.push_back(s);
  endtask

  // driver
  always @(posedge clk) begin
    motion_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        c.kind = in_req_type;
        c.steps = in_step_count;
        c.target = in_target_position;
        advance_motion(c);
        cmds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 25)) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_req_type <= c.kind;
          in_step_count <= c.steps;
          in_target_position <= c.target;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 25);
    end
  end

  // monitor
  always @(posedge clk) begin
    motor_status_t s;
    if (rst_n && out_valid && out_ready) begin
      status_seen++;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: pos %0d", out_position);
      end else begin
        s = expected_status.pop_front();
        if (out_step_level !== s.step_lvl || out_dir_level !== s.dir_lvl ||
            out_moving !== s.busy || out_position !== s.pos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp step %0b dir %0b moving %0b pos %0d, %s %0b %0b %0b %0d",
                     status_seen, s.step_lvl, s.dir_lvl, s.busy, s.pos, "got",
                     out_step_level, out_dir_level, out_moving, out_position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL stepper_ramp_pulse_generator");
      $finish;
    end
  end

  task automatic push_cmd(input logic [2:0] k, input logic [31:0] s, input logic [31:0] t);
    motion_cmd_t c;
    c.kind = k;
    c.steps = s;
    c.target = t;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == srpg_pkg::REG_START_INTERVAL) set_start = val;
    else if (idx == srpg_pkg::REG_MIN_INTERVAL) set_min = val[15:0];
  endtask

  task automatic random_cmds(input int count);
    int n, r, k;
    logic [31:0] s;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 65) begin
        k = $urandom_range(60, 1);
        repeat (k) push_cmd(srpg_pkg::REQ_TICK, $urandom, $urandom);
        n += k;
      end else begin
        if (r < 80) begin
          s = ($urandom_range(19) == 0) ? $urandom : $urandom_range(30);
          if ($urandom_range(1)) s = -s;
          push_cmd(srpg_pkg::REQ_REL_MOVE, s, $urandom);
        end else if (r < 88) begin
          s = ($urandom_range(19) == 0) ? $urandom : $urandom_range(100) - 50;
          push_cmd(srpg_pkg::REQ_ABS_MOVE, $urandom, s);
        end else if (r < 93) begin
          push_cmd(srpg_pkg::REQ_STOP, $urandom, $urandom);
        end else if (r < 97) begin
          push_cmd(srpg_pkg::REQ_ZERO_POS, $urandom, $urandom);
        end else begin
          push_cmd(3'($urandom_range(7, 5)), $urandom, $urandom);
        end
        n++;
      end
    end
  endtask

  initial begin
    set_start = srpg_pkg::START_INTERVAL_RST;
    set_min = srpg_pkg::MIN_INTERVAL_RST;
    m_pos = 0;
    m_total = 0;
    m_done = 0;
    m_ramp = 0;
    m_accel = 0;
    m_ivl = srpg_pkg::START_INTERVAL_RST;
    m_half = 0;
    m_wait = 0;
    m_pulse = 1'b0;
    m_neg = 1'b0;
    m_idle = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default registers
    push_cmd(srpg_pkg::REQ_REL_MOVE, 2, 0);
    repeat (40) push_cmd(srpg_pkg::REQ_TICK, $urandom, $urandom);
    random_cmds(40);
    wait_idle();

    // directed corners
    write_reg(srpg_pkg::REG_START_INTERVAL, 24'd1024);
    write_reg(srpg_pkg::REG_MIN_INTERVAL, 24'd1);
    push_cmd(srpg_pkg::REQ_REL_MOVE, 0, 0);
    repeat (3) push_cmd(srpg_pkg::REQ_TICK, 0, 0);
    push_cmd(srpg_pkg::REQ_REL_MOVE, 32'h8000_0000, 32'hFFFF_FFFF);
    repeat (4) push_cmd(srpg_pkg::REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(srpg_pkg::REQ_STOP, 0, 0);
    push_cmd(srpg_pkg::REQ_ABS_MOVE, 0, 32'h7FFF_FFFF);
    push_cmd(srpg_pkg::REQ_TICK, 0, 0);
    push_cmd(srpg_pkg::REQ_ABS_MOVE, 0, 32'h8000_0000);
    push_cmd(srpg_pkg::REQ_REL_MOVE, 32'h7FFF_FFFF, 0);
    push_cmd(3'd5, 32'h1234_5678, 32'h8765_4321);
    push_cmd(3'd6, 0, 0);
    push_cmd(3'd7, 32'hFFFF_FFFF, 0);
    push_cmd(srpg_pkg::REQ_ZERO_POS, 0, 0);
    push_cmd(srpg_pkg::REQ_TICK, 0, 0);
    random_cmds(300);
    wait_idle();

    write_reg(srpg_pkg::REG_START_INTERVAL, 24'd256);
    quiet = 1'b1;
    random_cmds(200);
    wait_idle();
    quiet = 1'b0;

    write_reg(srpg_pkg::REG_MIN_INTERVAL, 24'd65535);
    write_reg(srpg_pkg::REG_START_INTERVAL, 24'd2560);
    random_cmds(150);
    wait_idle();

    write_reg(srpg_pkg::REG_START_INTERVAL, 24'hFF_FFFF);
    write_reg(srpg_pkg::REG_MIN_INTERVAL, 24'd3);
    random_cmds(100);
    wait_idle();

    write_reg(srpg_pkg::REG_START_INTERVAL, 24'd700);
    write_reg(srpg_pkg::REG_MIN_INTERVAL, 24'd2);
    random_cmds(400);
    wait_idle();

    $display("covered %0d command/tick transactions, %0d status checks, %0d motor steps",
             cmds_sent, status_seen, steps_made);
    $display("six register settings incl. extreme intervals, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS stepper_ramp_pulse_generator");
    end else begin
      $display("FAIL stepper_ramp_pulse_generator");
    end
    $finish;
  end

endmodule
`default_nettype wire
